[design/hmac_transport_code_matcher_defines.svh]
// Assertion macros shared by the transport code matcher.
`ifndef HMAC_TRANSPORT_CODE_MATCHER_DEFINES_SVH
`define HMAC_TRANSPORT_CODE_MATCHER_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define HTCM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one on the following clock edge.
`define HTCM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[design/htcm_pkg.sv]
// Types, constants and SHA-256 helper functions of the transport code matcher.
package htcm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_PAYLOAD_DEF   = 255;

    localparam logic CMD_LEARN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic KIND_LEARN  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] LEARN_INSERTED = 2'd0;
    localparam logic [1:0] LEARN_KNOWN    = 2'd1;
    localparam logic [1:0] LEARN_FULL     = 2'd2;

    localparam logic [7:0]  IPAD_BYTE  = 8'h36;
    localparam logic [7:0]  OPAD_BYTE  = 8'h5c;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [15:0] CODE_ALL1  = 16'hFFFF;
    localparam logic [15:0] CODE_CLAMP = 16'hFFFE;
    localparam int          DIGEST_BITS = 768;

    localparam logic [255:0] SHA_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic        cmd;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [15:0] name_tag;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] code;
    } t_in_beat;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  learn_status;
        logic        matched;
        logic [5:0]  match_index;
        logic [15:0] matched_tag;
    } t_out_beat;

    function automatic logic [31:0] f_ep0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_ep1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ss0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_ss1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

[design/htcm_sha.sv]
// SHA-256 compression unit: one round per cycle over a 512-bit block.
module htcm_sha
    import htcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [511:0] i_block,
    input  logic [255:0] i_h,
    output logic         o_done,
    output logic [255:0] o_h
);

    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [255:0] r_hin;
    logic [255:0] r_hout;
    logic [5:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [31:0] n_v [8];

    always_comb begin
        t1 = r_v[7] + f_ep1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + ROUND_K[r_round] + r_w[0];
        t2 = f_ep0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = r_w[0] + f_ss0(r_w[1]) + r_w[9] + f_ss1(r_w[14]);
        n_v[0] = t1 + t2;
        n_v[1] = r_v[0];
        n_v[2] = r_v[1];
        n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1;
        n_v[5] = r_v[4];
        n_v[6] = r_v[5];
        n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                r_hin   <= i_h;
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= i_block[511 - 32 * i -: 32];
                end
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= i_h[255 - 32 * i -: 32];
                end
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= w_new;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= n_v[i];
                end
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    for (int i = 0; i < 8; i++) begin
                        r_hout[255 - 32 * i -: 32] <= r_hin[255 - 32 * i -: 32] + n_v[i];
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_h    = r_hout;

endmodule

[design/hmac_transport_code_matcher.sv]
// Top level of the transport code matcher: key table, message buffer and HMAC sequencer.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_stall   i_in_data  (t_in_beat)
//   out       output     o_out_valid / i_out_stall o_out_data (t_out_beat)
//
// A message byte that is not last is written to the buffer while it has room. A learn beat
// scans the tag memory entry by entry and answers on a matching tag or after the last entry.
// A lookup runs one HMAC per stored key, up to the first match, through a single SHA-256
// unit of 64 rounds, over ceil((L + 9) / 64) padded blocks of the L kept message bytes.
// Reset clears the entry count, message length and handshake state; memories keep data.
// A finished answer waits in the output register while a new beat is accepted.
`include "hmac_transport_code_matcher_defines.svh"

module hmac_transport_code_matcher
    import htcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int MSG_CAP = MAX_PAYLOAD + 1;
    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int MAW = $clog2(MSG_CAP);
    localparam int LW  = $clog2(MSG_CAP + 1);
    localparam int PW  = $clog2(MSG_CAP + 80) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_TSCAN, S_TCMP, S_KEY_RD, S_KEY_WT, S_FILL, S_HASH, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        PH_IPAD, PH_MSG, PH_OPAD, PH_OUTER
    } t_phase;

    logic [127:0] key_mem [TABLE_ENTRIES];
    logic [15:0]  tag_mem [TABLE_ENTRIES];
    logic [7:0]   msg_mem [MSG_CAP];

    t_state       r_state;
    t_phase       r_phase;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [LW-1:0] r_len;
    logic [15:0]  r_want;
    logic [15:0]  r_itag;
    logic [127:0] r_ikey;
    logic [127:0] r_key;
    logic [127:0] r_key_rd;
    logic [15:0]  r_tag_rd;
    logic [7:0]   r_msg_rd;
    logic [511:0] r_blk;
    logic [255:0] r_hcur;
    logic [255:0] r_inner;
    logic         r_start;
    logic [PW-7:0] r_bcnt;
    logic [6:0]   r_j;
    logic         r_fv;
    logic [5:0]   r_fj;
    logic         r_fsel;
    logic [7:0]   r_fconst;
    logic         r_blast;
    t_out_beat    r_res;
    t_out_beat    r_out;
    logic         r_ovalid;

    logic          in_fire;
    logic          core_done;
    logic [255:0]  core_h;
    logic [PW-1:0] pos;
    logic [PW-1:0] len_ext;
    logic [PW-1:0] blk_end;
    logic          fill_last;
    logic          pos_msg;
    logic [7:0]    pos_const;
    logic [63:0]   lenbits;
    logic [15:0]   code_raw;
    logic [15:0]  code_fix;
    logic [CW+5:0] idx_ext;
    logic [CW+5:0] cnt_ext;

    htcm_sha u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_block (r_blk),
        .i_h     (r_hcur),
        .o_done  (core_done),
        .o_h     (core_h)
    );

    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign idx_ext     = {6'b0, r_idx};
    assign cnt_ext     = {6'b0, r_count};

    // Byte source for the padded inner message stream, and the code taken from the digest.
    always_comb begin
        pos       = {r_bcnt, r_j[5:0]};
        len_ext   = {{(PW - LW){1'b0}}, r_len};
        blk_end   = {r_bcnt, 6'b0} + PW'(64);
        fill_last = (blk_end >= len_ext + PW'(9));
        lenbits   = ({{(64 - LW){1'b0}}, r_len} + 64'd64) << 3;
        pos_msg   = (pos < len_ext);
        if (pos == len_ext) begin
            pos_const = PAD_MARK;
        end else if (fill_last && (r_j[5:3] == 3'b111)) begin
            pos_const = lenbits[{~r_j[2:0], 3'b000} +: 8];
        end else begin
            pos_const = 8'h00;
        end
        code_raw = {core_h[247:240], core_h[255:248]};
        if (code_raw == 16'h0000) begin
            code_fix = 16'h0001;
        end else if (code_raw == CODE_ALL1) begin
            code_fix = CODE_CLAMP;
        end else begin
            code_fix = code_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_rd <= key_mem[r_idx[IW-1:0]];
        r_tag_rd <= tag_mem[r_idx[IW-1:0]];
        if (r_state == S_TSCAN && r_idx == r_count && r_count < CW'(TABLE_ENTRIES)) begin
            key_mem[r_count[IW-1:0]] <= r_ikey;
            tag_mem[r_count[IW-1:0]] <= r_itag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg_rd <= msg_mem[pos[MAW-1:0]];
        if (in_fire && i_in_data.cmd == CMD_BYTE && r_len < LW'(MSG_CAP)) begin
            msg_mem[r_len[MAW-1:0]] <= i_in_data.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
            r_fv     <= 1'b0;
            r_idx    <= '0;
            r_phase  <= PH_IPAD;
        end else begin
            // A start pulse lasts one cycle; no state raises it while it is high.
            if (r_start) begin
                r_start <= 1'b0;
            end
            if (r_ovalid && !i_out_stall && r_state != S_RESP) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_idx <= '0;
                        if (i_in_data.cmd == CMD_LEARN) begin
                            r_itag  <= i_in_data.name_tag;
                            r_ikey  <= {i_in_data.key_high, i_in_data.key_low};
                            r_state <= S_TSCAN;
                        end else begin
                            if (r_len < LW'(MSG_CAP)) begin
                                r_len <= r_len + LW'(1);
                            end
                            if (i_in_data.last_byte) begin
                                r_want  <= i_in_data.code;
                                r_res   <= {KIND_LOOKUP, 2'b00, 1'b0, 6'b0, 16'h0000};
                                if (i_in_data.code == 16'h0000 || r_count == '0) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_KEY_RD;
                                end
                            end
                        end
                    end
                end
                S_TSCAN: begin
                    if (r_idx == r_count) begin
                        if (r_count < CW'(TABLE_ENTRIES)) begin
                            r_res   <= {KIND_LEARN, LEARN_INSERTED, 1'b0, cnt_ext[5:0],
                                        16'h0000};
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_res   <= {KIND_LEARN, LEARN_FULL, 1'b0, 6'b0, 16'h0000};
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_TCMP;
                    end
                end
                S_TCMP: begin
                    if (r_tag_rd == r_itag) begin
                        r_res   <= {KIND_LEARN, LEARN_KNOWN, 1'b0, idx_ext[5:0], 16'h0000};
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_TSCAN;
                    end
                end
                S_KEY_RD: begin
                    r_state <= S_KEY_WT;
                end
                S_KEY_WT: begin
                    r_key   <= r_key_rd;
                    r_blk   <= {r_key_rd ^ {16{IPAD_BYTE}}, {48{IPAD_BYTE}}};
                    r_hcur  <= SHA_INIT;
                    r_phase <= PH_IPAD;
                    r_start <= 1'b1;
                    r_state <= S_HASH;
                end
                S_FILL: begin
                    // Two-stage fill: address and source are chosen, then the byte lands.
                    if (r_fv) begin
                        r_blk[{~r_fj, 3'b000} +: 8] <= r_fsel ? r_msg_rd : r_fconst;
                    end
                    if (!r_j[6]) begin
                        r_fv     <= 1'b1;
                        r_fj     <= r_j[5:0];
                        r_fsel   <= pos_msg;
                        r_fconst <= pos_const;
                        r_blast  <= fill_last;
                        r_j      <= r_j + 7'd1;
                    end else begin
                        r_fv <= 1'b0;
                        if (!r_fv) begin
                            r_phase <= PH_MSG;
                            r_start <= 1'b1;
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (core_done) begin
                        unique case (r_phase)
                            PH_IPAD: begin
                                r_hcur  <= core_h;
                                r_bcnt  <= '0;
                                r_j     <= '0;
                                r_state <= S_FILL;
                            end
                            PH_MSG: begin
                                if (r_blast) begin
                                    r_inner <= core_h;
                                    r_blk   <= {r_key ^ {16{OPAD_BYTE}}, {48{OPAD_BYTE}}};
                                    r_hcur  <= SHA_INIT;
                                    r_phase <= PH_OPAD;
                                    r_start <= 1'b1;
                                end else begin
                                    r_hcur  <= core_h;
                                    r_bcnt  <= r_bcnt + (PW-6)'(1);
                                    r_j     <= '0;
                                    r_state <= S_FILL;
                                end
                            end
                            PH_OPAD: begin
                                r_hcur  <= core_h;
                                r_blk   <= {r_inner, PAD_MARK, 184'b0, 64'(DIGEST_BITS)};
                                r_phase <= PH_OUTER;
                                r_start <= 1'b1;
                            end
                            PH_OUTER: begin
                                if (code_fix == r_want) begin
                                    r_res   <= {KIND_LOOKUP, 2'b00, 1'b1, idx_ext[5:0],
                                                r_tag_rd};
                                    r_state <= S_RESP;
                                end else if (r_idx + CW'(1) == r_count) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_idx   <= r_idx + CW'(1);
                                    r_state <= S_KEY_RD;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RESP: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        if (r_res.result_kind == KIND_LOOKUP) begin
                            r_len <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HTCM_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_ENTRIES), "entry count beyond table size")
    `HTCM_ASSERT_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= LW'(MSG_CAP), "message length beyond buffer")
    `HTCM_ASSERT_ALWAYS(a_learn_nomatch, i_clk, i_rst_n, !r_ovalid || r_out.result_kind == KIND_LOOKUP || !r_out.matched, "learn beat carries a match")
    `HTCM_ASSERT_NEXT(a_hash_hold, i_clk, i_rst_n, r_state == S_HASH && !core_done, r_state == S_HASH, "sequencer left hashing before the digest")

endmodule
